@@ src/blar_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bounded list core.
// Used by blar_cell, bounded_list_append_remove_core and blar_checker.
package blar_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int WORD_W       = 32;
   localparam int POS_W        = 4;
   localparam int CNT_OUT_W    = 5;
   // Index width wide enough for the largest supported capacity (256)
   localparam int CTL_W        = 9;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic             shift_en;  // cells in [shift_lo, shift_hi) take their neighbor
      logic [CTL_W-1:0] shift_lo;
      logic [CTL_W-1:0] shift_hi;
      logic             load_en;   // cell load_idx takes the broadcast word
      logic [CTL_W-1:0] load_idx;
   } ctl_type;

endpackage

@@ src/blar_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the list chain: holds a word, takes its tail-side
// neighbor on a shift or the broadcast word on a load. Depends on blar_pkg.
module blar_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  blar_pkg::ctl_type             ctl,
   input  logic signed [blar_pkg::WORD_W-1:0] bcast_word,
   input  logic signed [blar_pkg::WORD_W-1:0] next_word,
   output logic signed [blar_pkg::WORD_W-1:0] word
);
   import blar_pkg::*;

   localparam logic [CTL_W-1:0] MY_IDX = CTL_W'(INDEX);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic                     take_next;
   logic                     take_bcast;

   // local decode of the broadcast command
   assign take_next  = ctl.shift_en && (MY_IDX >= ctl.shift_lo) && (MY_IDX < ctl.shift_hi);
   assign take_bcast = ctl.load_en && (MY_IDX == ctl.load_idx);

   always_comb begin
      word_in = word_ff;
      if (take_next) begin
         word_in = next_word;
      end else if (take_bcast) begin
         word_in = bcast_word;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ src/bounded_list_append_remove_core.sv @@
`timescale 1ns / 1ps
// Bounded ordered list of signed words built as a chain of storage cells.
// Depends on blar_pkg and blar_cell.
//
// An edit (append, remove head, remove at position) is answered with a single
// beat that is ready in the next cycle; all cells shift in parallel. A dump of
// N entries first enters the dump state and then gives N beats, one per cycle
// while the result is not stalled: the head cell is read out and the occupied
// part of the chain rotates by one place per beat, ending in its original
// order. A single result register sits between the sides, so the next request
// is taken in the cycle the last beat leaves. Requests are not taken while a
// dump is running. rsp_count is the occupancy truncated to 5 bits. There is
// no clearing pass after reset.
module bounded_list_append_remove_core #(
   parameter int CAPACITY = blar_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic signed [blar_pkg::WORD_W-1:0]  req_value,
   input  logic [blar_pkg::POS_W-1:0]          req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [blar_pkg::WORD_W-1:0]  rsp_entry,
   output logic                                rsp_last,
   output logic [blar_pkg::CNT_OUT_W-1:0]      rsp_count
);
   import blar_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic signed [WORD_W-1:0]  rsp_entry_ff, rsp_entry_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [CNT_OUT_W-1:0]      rsp_count_ff, rsp_count_in;

   ctl_type                   ctl;
   logic signed [WORD_W-1:0]  bcast_word;
   logic signed [WORD_W-1:0]  words [CAPACITY];
   logic [CNT_W-1:0]          tail;
   logic                      slot_free;
   logic                      accept;
   logic                      is_empty;

   // cell chain: cell i takes cell i+1 on a shift
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [WORD_W-1:0] nb_word;
      if (g == CAPACITY - 1) begin : g_end
         assign nb_word = '0;
      end else begin : g_mid
         assign nb_word = words[g+1];
      end
      blar_cell #(.INDEX(g)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .bcast_word (bcast_word),
         .next_word  (nb_word),
         .word       (words[g])
      );
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign tail      = count_ff - CNT_W'(1);
   assign is_empty  = (count_ff == '0);

   // command decode and next-state logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      ctl           = '0;
      bcast_word    = req_value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_entry_in = '0;
               rsp_last_in  = 1'b1;
               case (cmd_type'(req_command))
                  CMD_APPEND: begin
                     if (count_ff == CAP_CNT) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.load_en   = 1'b1;
                        ctl.load_idx  = CTL_W'(count_ff);
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = ST_OK;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  CMD_POP: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ctl.shift_en  = 1'b1;
                        ctl.shift_lo  = '0;
                        ctl.shift_hi  = CTL_W'(tail);
                        count_in      = tail;
                        rsp_status_in = ST_OK;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  CMD_REMOVE: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (32'(req_position) >= 32'(count_ff)) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        ctl.shift_en  = 1'b1;
                        ctl.shift_lo  = CTL_W'(req_position);
                        ctl.shift_hi  = CTL_W'(tail);
                        count_in      = tail;
                        rsp_status_in = ST_OK;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  CMD_DUMP: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_count_in = CNT_OUT_W'(count_in);
            end
         end
         S_DUMP: begin
            // read the head, rotate the occupied cells by one place
            if (slot_free) begin
               ctl.shift_en  = 1'b1;
               ctl.shift_lo  = '0;
               ctl.shift_hi  = CTL_W'(tail);
               ctl.load_en   = 1'b1;
               ctl.load_idx  = CTL_W'(tail);
               bcast_word    = words[0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_entry_in  = words[0];
               rsp_last_in   = (idx_ff == tail);
               rsp_count_in  = CNT_OUT_W'(count_ff);
               idx_in        = idx_ff + CNT_W'(1);
               if (idx_ff == tail) begin
                  state_in = S_IDLE;
                  idx_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

@@ src/blar_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for bounded_list_append_remove_core, bound to the top.
// Depends on blar_pkg.
module blar_checker #(
   parameter int CAPACITY = blar_pkg::DEF_CAPACITY
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [1:0]                          req_command,
   input logic signed [blar_pkg::WORD_W-1:0]  req_value,
   input logic [blar_pkg::POS_W-1:0]          req_position,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          rsp_status,
   input logic signed [blar_pkg::WORD_W-1:0]  rsp_entry,
   input logic                                rsp_last,
   input logic [blar_pkg::CNT_OUT_W-1:0]      rsp_count
);
   import blar_pkg::*;

   // a refused command is a single beat with a zero entry
   a_refused_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last && (rsp_entry == '0))
      else $error("refused command beat has entry or is not last");

   // full refusal only at capacity, empty refusal only at zero
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_count == CNT_OUT_W'(CAPACITY))
      else $error("full status with count below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_count == '0)
      else $error("empty status with nonzero count");

   // count does not move inside a dump
   a_dump_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_count == $past(rsp_count))
      else $error("count changed between beats of a dump");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry) && $stable(rsp_status))
      else $error("result beat changed while stalled");

endmodule

bind bounded_list_append_remove_core blar_checker #(.CAPACITY(CAPACITY)) u_blar_checker (.*);
